// ===== design/sector_cache_clock_directory_defines.svh =====
// Assertion macros for the sector cache clock directory.
`ifndef SECTOR_CACHE_CLOCK_DIRECTORY_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_DIRECTORY_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scd check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define SCD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scd check failed");

`endif

// ===== design/scd_pkg.sv =====
// Shared types and constants of the sector cache clock directory.
`default_nettype none
package scd_pkg;
	localparam int ENTRIES_DEF  = 64;
	localparam int TAG_BITS_DEF = 32;
	localparam int SECTOR_W     = 32;
	localparam int SLOT_W       = 6;
	localparam int MAX_FLUSH    = 64;
	localparam int FLUSH_CNT_W  = 7;
	localparam int Q_DEPTH      = 2;
	localparam int Q_AW         = 1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [SECTOR_W-1:0] sector;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_CLK,
		B_WB,
		B_UPD,
		B_FSCAN,
		B_FRD,
		B_FEND
	} bstate_t;
endpackage
`default_nettype wire

// ===== design/sector_cache_clock_directory.sv =====
// Top level of the sector cache clock directory: intake queue plus engine.
// Access: a serial tag scan through the one-port tag store, which stops at a hit; on a full miss
//   a clock-hand walk follows, and a dirty victim's tag is read from the store for the writeback.
// Flush: walks the slots and reads each dirty one; one beat per dirty slot, or one closing beat if none.
// The intake queue holds two requests, so requests are taken while the engine works.
// Reset (arst_n low) frees every slot and clears dirty and accessed marks, hand and counters.
`default_nettype none
`include "sector_cache_clock_directory_defines.svh"
module sector_cache_clock_directory
	import scd_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic [1:0]          op,
	input  wire logic [SECTOR_W-1:0] sector,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [SLOT_W-1:0]        slot,
	output logic                     hit,
	output logic                     fill_needed,
	output logic                     writeback_valid,
	output logic [SECTOR_W-1:0]      writeback_sector,
	output logic                     last,
	output logic [31:0]              hit_total,
	output logic [31:0]              access_total
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	// Front end: take request beats, drop undefined ops, queue the rest.
	scd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.op        (op),
		.sector    (sector),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back end: look up, replace, flush, and hold each result beat until taken.
	scd_back #(
		.ENTRIES  (ENTRIES),
		.TAG_BITS (TAG_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.cmd              (cmd),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.slot             (slot),
		.hit              (hit),
		.fill_needed      (fill_needed),
		.writeback_valid  (writeback_valid),
		.writeback_sector (writeback_sector),
		.last             (last),
		.hit_total        (hit_total),
		.access_total     (access_total)
	);

	// A hit never asks for a fill or a writeback.
	`SCD_ASSERT_IMP(a_hit_clean, rsp_valid && hit, !fill_needed && !writeback_valid)
	// Only flush beats come before the last one, and each carries a writeback.
	`SCD_ASSERT_IMP(a_mid_is_wb, rsp_valid && !last, writeback_valid && !hit)
	// No writeback means an empty writeback sector.
	`SCD_ASSERT_IMP(a_wb_zero, rsp_valid && !writeback_valid, writeback_sector == '0)
	// The engine is busy right after taking a command.
	`SCD_ASSERT_NXT(a_busy, cmd_valid && cmd_ready, !cmd_ready)
endmodule
`default_nettype wire

// ===== design/scd_front.sv =====
// Request intake: drops undefined ops and queues the rest for the back end.
`default_nettype none
module scd_front
	import scd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic [1:0]          op,
	input  wire logic [SECTOR_W-1:0] sector,
	output logic                     cmd_valid,
	input  wire logic                cmd_ready,
	output cmd_t                     cmd
);
	cmd_t                 q_q [Q_DEPTH];
	logic [Q_AW-1:0]      wp_q, rp_q;
	logic [Q_AW:0]        cnt_q;
	logic                 op_ok, push, pop;

	assign op_ok     = (op == OP_READ) || (op == OP_WRITE) || (op == OP_FLUSH);
	assign req_ready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign push      = req_valid && req_ready && op_ok;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{op: op_t'(op), sector: sector};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == Q_AW'(Q_DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == Q_AW'(Q_DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/scd_back.sv =====
// Directory engine: tag scan, clock replacement, flush walk, result register.
`default_nettype none
module scd_back
	import scd_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire cmd_t                cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [SLOT_W-1:0]        slot,
	output logic                     hit,
	output logic                     fill_needed,
	output logic                     writeback_valid,
	output logic [SECTOR_W-1:0]      writeback_sector,
	output logic                     last,
	output logic [31:0]              hit_total,
	output logic [31:0]              access_total
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES-1);

	bstate_t               state_q, state_d;
	op_t                   op_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [IDX_W-1:0]      idx_q, rd_idx_q, slot_q, free_q, hand_q, pend_idx_q;
	logic                  done_q, cmp_vld_q, found_q, free_vld_q, wbv_q, pend_vld_q;
	logic [TAG_BITS-1:0]   rd_q, wbs_q, pend_tag_q;
	logic [ENTRIES-1:0]    used_q, dirty_q, ref_q;
	logic [31:0]           hits_q, acc_q;
	logic [FLUSH_CNT_W-1:0] k_q;
	logic [TAG_BITS-1:0]   tag_mem [ENTRIES];

	logic                  out_free, hit_now, cmp_last, flush_stop;
	logic                  rd_en, wr_en, emit;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      e_slot;
	logic                  e_hit, e_fill, e_wbv, e_last;
	logic [TAG_BITS-1:0]   e_wbs;
	logic [31:0]           e_hits, e_acc;

	assign out_free   = !rsp_valid || rsp_ready;
	assign hit_now    = cmp_vld_q && used_q[rd_idx_q] && (rd_q == tag_q);
	assign cmp_last   = cmp_vld_q && (rd_idx_q == LAST_IDX);
	assign flush_stop = done_q || (k_q == FLUSH_CNT_W'(MAX_FLUSH));
	assign cmd_ready  = (state_q == B_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.op == OP_FLUSH) ? B_FSCAN : B_SCAN;
				end
			end
			B_SCAN: begin
				if (hit_now) begin
					state_d = B_UPD;
				end else if (cmp_last) begin
					state_d = free_vld_q ? B_UPD : B_CLK;
				end
			end
			B_CLK: begin
				if (!ref_q[hand_q]) begin
					state_d = dirty_q[hand_q] ? B_WB : B_UPD;
				end
			end
			B_WB:    state_d = B_UPD;
			B_UPD: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_FSCAN: begin
				if (flush_stop) begin
					state_d = B_FEND;
				end else if (dirty_q[idx_q]) begin
					state_d = B_FRD;
				end
			end
			B_FRD: begin
				if (!pend_vld_q || out_free) begin
					state_d = B_FSCAN;
				end
			end
			B_FEND: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// strobes and result fields
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		emit    = 1'b0;
		e_slot  = slot_q;
		e_hit   = 1'b0;
		e_fill  = 1'b0;
		e_wbv   = 1'b0;
		e_wbs   = '0;
		e_last  = 1'b1;
		e_hits  = hits_q;
		e_acc   = acc_q;
		unique case (state_q)
			B_SCAN:  rd_en = !done_q;
			B_CLK: begin
				rd_addr = hand_q;
				rd_en   = !ref_q[hand_q] && dirty_q[hand_q];
			end
			B_UPD: begin
				emit   = out_free;
				wr_en  = out_free && !found_q;
				rd_addr = slot_q;
				e_hit  = found_q;
				e_fill = !found_q && (op_q == OP_READ);
				e_wbv  = wbv_q;
				e_wbs  = wbs_q;
				e_hits = hits_q + 32'(found_q);
				e_acc  = acc_q + 32'd1;
			end
			B_FSCAN: rd_en = !flush_stop && dirty_q[idx_q];
			B_FRD: begin
				emit   = pend_vld_q && out_free;
				e_slot = pend_idx_q;
				e_wbv  = 1'b1;
				e_wbs  = pend_tag_q;
				e_last = 1'b0;
			end
			B_FEND: begin
				emit   = out_free;
				e_slot = pend_vld_q ? pend_idx_q : '0;
				e_wbv  = pend_vld_q;
				e_wbs  = pend_vld_q ? pend_tag_q : '0;
			end
			default: begin
			end
		endcase
	end

	// tag store, single port, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= tag_mem[rd_addr];
		end
		if (wr_en) begin
			tag_mem[slot_q] <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			op_q       <= OP_READ;
			tag_q      <= '0;
			idx_q      <= '0;
			rd_idx_q   <= '0;
			slot_q     <= '0;
			free_q     <= '0;
			hand_q     <= '0;
			pend_idx_q <= '0;
			pend_tag_q <= '0;
			done_q     <= 1'b0;
			cmp_vld_q  <= 1'b0;
			found_q    <= 1'b0;
			free_vld_q <= 1'b0;
			wbv_q      <= 1'b0;
			wbs_q      <= '0;
			pend_vld_q <= 1'b0;
			used_q     <= '0;
			dirty_q    <= '0;
			ref_q      <= '0;
			hits_q     <= '0;
			acc_q      <= '0;
			k_q        <= '0;
			rsp_valid  <= 1'b0;
			slot             <= '0;
			hit              <= 1'b0;
			fill_needed      <= 1'b0;
			writeback_valid  <= 1'b0;
			writeback_sector <= '0;
			last             <= 1'b0;
			hit_total        <= '0;
			access_total     <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (emit) begin
				rsp_valid        <= 1'b1;
				slot             <= SLOT_W'(e_slot);
				hit              <= e_hit;
				fill_needed      <= e_fill;
				writeback_valid  <= e_wbv;
				writeback_sector <= SECTOR_W'(e_wbs);
				last             <= e_last;
				hit_total        <= e_hits;
				access_total     <= e_acc;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						op_q       <= cmd.op;
						tag_q      <= cmd.sector[TAG_BITS-1:0];
						idx_q      <= '0;
						done_q     <= 1'b0;
						cmp_vld_q  <= 1'b0;
						free_vld_q <= 1'b0;
						wbv_q      <= 1'b0;
						wbs_q      <= '0;
						k_q        <= '0;
						pend_vld_q <= 1'b0;
					end
				end
				B_SCAN: begin
					cmp_vld_q <= !done_q;
					rd_idx_q  <= idx_q;
					if (!done_q) begin
						// remember the lowest free slot on the way past
						if (!used_q[idx_q] && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_q     <= idx_q;
						end
						if (idx_q == LAST_IDX) begin
							done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					found_q <= hit_now;
					slot_q  <= hit_now ? rd_idx_q : free_q;
				end
				B_CLK: begin
					if (ref_q[hand_q]) begin
						ref_q[hand_q] <= 1'b0;
						hand_q <= (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
					end else begin
						slot_q <= hand_q;
					end
				end
				B_WB: begin
					wbv_q <= 1'b1;
					wbs_q <= rd_q;
				end
				B_UPD: begin
					if (out_free) begin
						acc_q  <= acc_q + 32'd1;
						hits_q <= hits_q + 32'(found_q);
						if (!found_q) begin
							used_q[slot_q] <= 1'b1;
						end
						ref_q[slot_q]   <= 1'b1;
						dirty_q[slot_q] <= (op_q == OP_WRITE) || (found_q && dirty_q[slot_q]);
					end
				end
				B_FSCAN: begin
					if (!flush_stop && !dirty_q[idx_q]) begin
						if (idx_q == LAST_IDX) begin
							done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_FRD: begin
					if (!pend_vld_q || out_free) begin
						pend_vld_q     <= 1'b1;
						pend_idx_q     <= idx_q;
						pend_tag_q     <= rd_q;
						dirty_q[idx_q] <= 1'b0;
						k_q            <= k_q + 1'b1;
						if (idx_q == LAST_IDX) begin
							done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				B_FEND: begin
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire
